### rtl/double_to_fixed2_text_assert.svh
// Assertion macros shared by the RTL files. Each expects clk and rst in scope.
`ifndef DOUBLE_TO_FIXED2_TEXT_ASSERT_SVH
`define DOUBLE_TO_FIXED2_TEXT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define D2FT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define D2FT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/d2ft_pkg.sv
package d2ft_pkg;

  // Scaled value n = round(100 * |x|) stays below 1e23.
  localparam int N_W    = 77;
  localparam int NDIG   = 23;
  localparam int BCD_W  = 4 * NDIG;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 7;
  localparam int AM_W   = 62;
  localparam int SH_W   = 5;
  localparam int RS_W   = 6;

  localparam int QUEUE_DEPTH = 2;
  localparam int NAN_LEN     = 3;

  localparam logic [62:0] MAG_1E21     = 63'h444B1AE4D6E2EF50;
  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [10:0] EXP_UNITY    = 11'd1075;
  localparam logic [10:0] SUBN_SHIFT   = 11'd1074;
  localparam logic [10:0] MAX_RSHIFT   = 11'd61;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_NUM = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NAN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OOR = 2'd2;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BIG_N = 8'h4E;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_NONE  = 8'h00;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              neg;
    logic [N_W-1:0]    n;
  } entry_t;

endpackage

### rtl/d2ft_front.sv
module d2ft_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [63:0]       value_bits,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              push,
  output d2ft_pkg::entry_t  push_entry,
  input  logic              full
);

  // Stage 0: captured raw bits.
  logic        v0;
  logic [63:0] raw;

  // Stage 1: classified item with the scaled significand.
  logic                          v1;
  logic [d2ft_pkg::KIND_W-1:0]   kind1;
  logic                          neg1;
  logic                          pos1;
  logic                          zero1;
  logic [d2ft_pkg::SH_W-1:0]     sh1;
  logic [d2ft_pkg::RS_W-1:0]     rs1;
  logic [d2ft_pkg::AM_W-1:0]     am1;
  logic [d2ft_pkg::AM_W-1:0]     rnd1;

  logic [10:0]                   expo;
  logic [51:0]                   mant;
  logic [62:0]                   mag;
  logic [52:0]                   m;
  logic [d2ft_pkg::AM_W-1:0]     mx;
  logic [d2ft_pkg::AM_W-1:0]     am0;
  logic [d2ft_pkg::AM_W-1:0]     rnd0;
  logic [10:0]                   diff0;
  logic [10:0]                   s0;
  logic                          pos0;
  logic                          big0;
  logic                          is_nan;
  logic                          is_oor;
  logic [d2ft_pkg::KIND_W-1:0]   kind0;

  logic [d2ft_pkg::AM_W-1:0]     t1;
  logic [d2ft_pkg::N_W:0]        shl1;
  logic [d2ft_pkg::N_W-1:0]      n1;
  logic                          adv1;

  always_comb begin
    expo   = raw[62:52];
    mant   = raw[51:0];
    mag    = raw[62:0];
    is_nan = (expo == d2ft_pkg::EXP_ALL_ONES) && (mant != 52'd0);
    is_oor = (mag >= d2ft_pkg::MAG_1E21);
    if (is_nan) begin
      kind0 = d2ft_pkg::KIND_NAN;
    end else if (is_oor) begin
      kind0 = d2ft_pkg::KIND_OOR;
    end else begin
      kind0 = d2ft_pkg::KIND_NUM;
    end
    m     = {(expo != 11'd0), mant};
    mx    = d2ft_pkg::AM_W'(m);
    // 200 * m as 128m + 64m + 8m.
    am0   = (mx << 7) + (mx << 6) + (mx << 3);
    pos0  = (expo >= d2ft_pkg::EXP_UNITY);
    diff0 = expo - d2ft_pkg::EXP_UNITY;
    s0    = (expo == 11'd0) ? d2ft_pkg::SUBN_SHIFT : (d2ft_pkg::EXP_UNITY - expo);
    big0  = (s0 >= d2ft_pkg::MAX_RSHIFT);
    if (pos0 || big0) begin
      rnd0 = '0;
    end else begin
      rnd0 = d2ft_pkg::AM_W'(1) << s0[d2ft_pkg::RS_W-1:0];
    end
  end

  // For a non-negative exponent, (200m << e) >> 1 is exactly 100m << e.
  always_comb begin
    t1   = am1 + rnd1;
    shl1 = (d2ft_pkg::N_W + 1)'(t1) << sh1;
    if (pos1) begin
      n1 = shl1[d2ft_pkg::N_W:1];
    end else if (zero1) begin
      n1 = '0;
    end else begin
      n1 = d2ft_pkg::N_W'(t1 >> rs1);
    end
  end

  assign push            = v1 && !full;
  assign adv1            = v0 && (!v1 || push);
  assign in_ready        = !v0 || adv1;
  assign push_entry.kind = kind1;
  assign push_entry.neg  = neg1;
  assign push_entry.n    = n1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        v0 <= 1'b1;
      end else if (adv1) begin
        v0 <= 1'b0;
      end
      if (adv1) begin
        v1 <= 1'b1;
      end else if (push) begin
        v1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw <= value_bits;
    end
    if (adv1) begin
      kind1 <= kind0;
      neg1  <= raw[63] && (mag != 63'd0);
      pos1  <= pos0;
      zero1 <= big0;
      sh1   <= diff0[d2ft_pkg::SH_W-1:0];
      rs1   <= s0[d2ft_pkg::RS_W-1:0] + d2ft_pkg::RS_W'(1);
      am1   <= am0;
      rnd1  <= rnd0;
    end
  end

endmodule

### rtl/d2ft_queue.sv
`include "double_to_fixed2_text_assert.svh"

module d2ft_queue #(
  parameter int DEPTH = d2ft_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  d2ft_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output d2ft_pkg::entry_t  pop_entry,
  output logic              empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  d2ft_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == CW'(0));
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `D2FT_ASSERT_NOW(a_q_no_overrun, 1'b1, count <= CW'(DEPTH), "queue holds more than its depth")
  `D2FT_ASSERT_NOW(a_q_no_underrun, pop, !empty, "pop from an empty queue")

endmodule

### rtl/d2ft_back.sv
`include "double_to_fixed2_text_assert.svh"

module d2ft_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  output logic              pop,
  input  d2ft_pkg::entry_t  pop_entry,
  output logic [7:0]        text_char,
  output logic              last,
  output logic              status,
  output logic              out_valid,
  input  logic              out_ready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_LEAD = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_DIG  = 3'd4;
  localparam logic [2:0] ST_NAN  = 3'd5;
  localparam logic [2:0] ST_OOR  = 3'd6;

  logic [2:0]                    state;
  logic                          neg;
  logic [d2ft_pkg::N_W-1:0]      bin;
  logic [d2ft_pkg::BCD_W-1:0]    bcd;
  logic [d2ft_pkg::CNT_W-1:0]    cnt;
  logic [d2ft_pkg::IDX_W-1:0]    idx;
  logic                          dot_done;

  logic [d2ft_pkg::BCD_W-1:0]    bcd_adj;
  logic [d2ft_pkg::BCD_W-1:0]    bcd_next;
  logic [d2ft_pkg::IDX_W-1:0]    lead_idx;
  logic [3:0]                    digit;
  logic                          slot;
  logic                          emit;

  // Shift-and-add-3 step: each BCD digit of five or more gets 3 before the shift.
  always_comb begin
    for (int j = 0; j < d2ft_pkg::NDIG; j++) begin
      if (bcd[4*j +: 4] >= 4'd5) begin
        bcd_adj[4*j +: 4] = bcd[4*j +: 4] + 4'd3;
      end else begin
        bcd_adj[4*j +: 4] = bcd[4*j +: 4];
      end
    end
    bcd_next = {bcd_adj[d2ft_pkg::BCD_W-2:0], bin[d2ft_pkg::N_W-1]};
  end

  // Highest nonzero digit, padded so that at least three digits are printed.
  always_comb begin
    lead_idx = d2ft_pkg::IDX_W'(2);
    for (int j = 3; j < d2ft_pkg::NDIG; j++) begin
      if (bcd[4*j +: 4] != 4'd0) begin
        lead_idx = d2ft_pkg::IDX_W'(j);
      end
    end
  end

  assign digit = bcd[{idx, 2'b00} +: 4];
  assign slot  = !out_valid || out_ready;
  assign pop   = (state == ST_IDLE) && !empty;
  assign emit  = slot && (state inside {ST_SIGN, ST_DIG, ST_NAN, ST_OOR});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            neg <= pop_entry.neg;
            bin <= pop_entry.n;
            bcd <= '0;
            cnt <= '0;
            case (pop_entry.kind)
              d2ft_pkg::KIND_NAN: state <= ST_NAN;
              d2ft_pkg::KIND_OOR: state <= ST_OOR;
              default:            state <= ST_CONV;
            endcase
          end
        end
        ST_CONV: begin
          bcd <= bcd_next;
          bin <= bin << 1;
          cnt <= cnt + d2ft_pkg::CNT_W'(1);
          if (cnt == d2ft_pkg::CNT_W'(d2ft_pkg::N_W - 1)) begin
            state <= ST_LEAD;
          end
        end
        ST_LEAD: begin
          idx      <= lead_idx;
          dot_done <= 1'b0;
          state    <= neg ? ST_SIGN : ST_DIG;
        end
        ST_SIGN: begin
          if (slot) begin
            text_char <= d2ft_pkg::CH_MINUS;
            last      <= 1'b0;
            status    <= 1'b0;
            state     <= ST_DIG;
          end
        end
        ST_DIG: begin
          if (slot) begin
            status    <= 1'b0;
            // The point goes in front of the second-to-last digit.
            if ((idx == d2ft_pkg::IDX_W'(1)) && !dot_done) begin
              text_char <= d2ft_pkg::CH_DOT;
              last      <= 1'b0;
              dot_done  <= 1'b1;
            end else begin
              text_char <= d2ft_pkg::CH_ZERO + {4'b0000, digit};
              last      <= (idx == '0);
              if (idx == '0) begin
                state <= ST_IDLE;
              end else begin
                idx <= idx - d2ft_pkg::IDX_W'(1);
              end
            end
          end
        end
        ST_NAN: begin
          if (slot) begin
            text_char <= (cnt == d2ft_pkg::CNT_W'(1)) ? d2ft_pkg::CH_LOW_A
                                                      : d2ft_pkg::CH_BIG_N;
            status    <= 1'b0;
            last      <= (cnt == d2ft_pkg::CNT_W'(d2ft_pkg::NAN_LEN - 1));
            cnt       <= cnt + d2ft_pkg::CNT_W'(1);
            if (cnt == d2ft_pkg::CNT_W'(d2ft_pkg::NAN_LEN - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_OOR: begin
          if (slot) begin
            text_char <= d2ft_pkg::CH_NONE;
            last      <= 1'b1;
            status    <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `D2FT_ASSERT_NOW(a_oor_alone, out_valid && status, last && (text_char == d2ft_pkg::CH_NONE), "out-of-range result must be a single empty item")
  `D2FT_ASSERT_NOW(a_conv_bound, state == ST_CONV, cnt < d2ft_pkg::CNT_W'(d2ft_pkg::N_W), "conversion ran past the width of n")
  `D2FT_ASSERT_NEXT(a_lead_range, state == ST_LEAD, (idx >= d2ft_pkg::IDX_W'(2)) && (idx < d2ft_pkg::IDX_W'(d2ft_pkg::NDIG)), "leading digit index out of range")

endmodule

### rtl/double_to_fixed2_text.sv
// Channel  Handshake                Payload
// input    in_valid / in_ready      value_bits[63:0]
// output   out_valid / out_ready    text_char[7:0], last, status
//
// A number passes the front stages and the queue, is popped by the back end, runs
// the 77-step double-dabble binary-to-BCD shift loop, has its leading digit found,
// and is then sent one character per cycle while out_ready is high (4 to 25 characters).
// A NaN or an out-of-range value skips the shift loop and the leading-digit search.
// rst (synchronous) empties both front stages, the queue and the output register.
// The front keeps taking items while the back end converts, until the queue is full;
// a low out_ready holds the output register and stalls only the back end.
module double_to_fixed2_text #(
  parameter int QDEPTH = d2ft_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] value_bits,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [7:0]  text_char,
  output logic        last,
  output logic        status,
  output logic        out_valid,
  input  logic        out_ready
);

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  d2ft_pkg::entry_t push_entry;
  d2ft_pkg::entry_t pop_entry;

  d2ft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .value_bits (value_bits),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  d2ft_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  d2ft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop       (pop),
    .pop_entry (pop_entry),
    .text_char (text_char),
    .last      (last),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
